// ----- hdl/key1_pkg.sv -----
// Package with shared constants and types of the KEY1 cipher core.
package key1_pkg;
    localparam int TABLE_WORDS_DEF = 1042;
    localparam int AW = 11;
    localparam logic [AW-1:0] SBOX0 = 11'h012;
    localparam logic [AW-1:0] SBOX1 = 11'h112;
    localparam logic [AW-1:0] SBOX2 = 11'h212;
    localparam logic [AW-1:0] SBOX3 = 11'h312;
    localparam logic [4:0] LAST_ROUND = 5'h11;
    localparam logic [AW-1:0] REBUILD_LAST = 11'h410;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_ENC  = 2'd1,
        OP_DEC  = 2'd2,
        OP_INIT = 2'd3
    } t_opcode;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [10:0] word_index;
        logic [31:0] word_value;
        logic [63:0] block_in;
        logic [1:0]  key_level;
        logic [1:0]  code_modulo;
    } t_in_item;

    typedef struct packed {
        logic [63:0] block_out;
        logic        block_valid;
    } t_out_item;

    function automatic logic [31:0] swap_bytes(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction
endpackage

// ----- hdl/key1_if.sv -----
// Valid/ready channel interfaces for input and result beats.
interface key1_in_if;
    import key1_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface key1_out_if;
    import key1_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// ----- hdl/key1_block_cipher_with_key_schedule_core.sv -----
// Top level of the KEY1 block cipher core with key-code schedule.
//
//  channel   dir   handshake      payload
//  in_ch     in    valid/ready    opcode, word_index, word_value, block_in,
//                                 key_level, code_modulo
//  out_ch    out   valid/ready    block_out, block_valid
//  cfg       in    i_cfg_we       i_cfg_data (game_code)
//
// The key table sits in one single-port synchronous memory with a registered
// read port. A cipher round makes five reads (round word plus four S-box
// words), each issued in the cycle the previous data returns. Init runs up
// to three applies, each made of two encryptions, 18 read-modify-writes and
// 521 chained decryptions. Reset is synchronous and active low; it clears
// control state and the code words, not the table. The input is held off
// while an item is in work and while the result register is full.
module key1_block_cipher_with_key_schedule_core
#(
    parameter int TABLE_WORDS = key1_pkg::TABLE_WORDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    key1_in_if.sink     in_ch,
    key1_out_if.source  out_ch
);
    import key1_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_CIPH  = 12'b000000000010, // start a block: issue round word read
        S_RWAIT = 12'b000000000100, // round word arrives
        S_SB    = 12'b000000001000, // S-box reads
        S_FIN0  = 12'b000000010000, // whitening read 1
        S_FIN1  = 12'b000000100000, // whitening read 2
        S_DONE  = 12'b000001000000, // block finished, dispatch
        S_XRD   = 12'b000010000000, // round word xor: read
        S_XWR   = 12'b000100000000, // round word xor: write
        S_RBW0  = 12'b001000000000, // rebuild: unused, the upper word is written in S_DONE
        S_RBW1  = 12'b010000000000, // rebuild: write lower word
        S_OUT   = 12'b100000000000
    } t_state;

    // Phase of the init sequence that owns the running cipher.
    typedef enum logic [1:0] {
        P_USER = 2'd0,
        P_ENC1 = 2'd1,
        P_ENC2 = 2'd2,
        P_RBLD = 2'd3
    } t_phase;

    logic [31:0] mem [TABLE_WORDS];
    logic [31:0] r_rdata;
    logic        mem_we;
    logic [AW-1:0] mem_addr;
    logic [31:0] mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        r_rdata <= mem[mem_addr];
    end

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic [31:0] r_game, r_cw0, r_cw1, r_cw2, n_cw0, n_cw1, n_cw2;
    logic [31:0] r_x, r_y, r_z, r_f, n_x, n_y, n_z, n_f;
    logic [4:0]  r_round, n_round;
    logic [2:0]  r_sb, n_sb;
    logic        r_dec, n_dec;
    logic [1:0]  r_apps, n_apps;   // applies still to run
    logic        r_half, n_half;   // mid-init code word adjust done
    logic [1:0]  r_mod, n_mod;
    logic [1:0]  r_imod, n_imod;   // i mod modulus
    logic [AW-1:0] r_idx, n_idx;
    logic        r_ovld, n_ovld;
    t_out_item   r_out, n_out;
    t_in_item    r_item, n_item;

    logic [31:0] sb_acc;
    logic [31:0] cw_sel;

    always_comb begin
        case (r_sb)
            3'd1: sb_acc = r_rdata + r_f;
            3'd2: sb_acc = r_rdata ^ r_f;
            3'd3: sb_acc = r_rdata + r_f;
            default: sb_acc = r_rdata;
        endcase
        case (r_imod)
            2'd1: cw_sel = r_cw1;
            2'd2: cw_sel = r_cw2;
            default: cw_sel = r_cw0;
        endcase
    end

    assign in_ch.ready  = (r_state == S_IDLE) && !r_ovld;
    assign out_ch.valid = r_ovld;
    assign out_ch.data  = r_out;

    logic in_fire;
    assign in_fire = in_ch.valid && in_ch.ready;

    always_comb begin
        n_state = r_state;  n_phase = r_phase;
        n_cw0 = r_cw0; n_cw1 = r_cw1; n_cw2 = r_cw2;
        n_x = r_x; n_y = r_y; n_z = r_z; n_f = r_f;
        n_round = r_round; n_sb = r_sb; n_dec = r_dec;
        n_apps = r_apps; n_half = r_half; n_mod = r_mod; n_imod = r_imod;
        n_idx = r_idx; n_ovld = r_ovld; n_out = r_out; n_item = r_item;
        mem_we = 1'b0; mem_addr = '0; mem_wdata = '0;
        if (out_ch.ready) begin
            n_ovld = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_item = in_ch.data;
                    case (t_opcode'(in_ch.data.opcode))
                        OP_LOAD: begin
                            if (in_ch.data.word_index < AW'(TABLE_WORDS)) begin
                                mem_we    = 1'b1;
                                mem_addr  = in_ch.data.word_index;
                                mem_wdata = in_ch.data.word_value;
                            end
                            n_out.block_out = '0; n_out.block_valid = 1'b0;
                            n_state = S_OUT;
                        end
                        OP_ENC, OP_DEC: begin
                            n_phase = P_USER;
                            n_dec = (in_ch.data.opcode == OP_DEC);
                            n_x = in_ch.data.block_in[63:32];
                            n_y = in_ch.data.block_in[31:0];
                            n_round = (in_ch.data.opcode == OP_DEC) ? LAST_ROUND : 5'd0;
                            n_state = S_CIPH;
                        end
                        default: begin
                            n_cw0 = r_game; n_cw1 = r_game >> 1; n_cw2 = r_game << 1;
                            n_mod = (in_ch.data.code_modulo == 2'd0) ? 2'd1
                                                                     : in_ch.data.code_modulo;
                            n_apps = in_ch.data.key_level;
                            n_half = 1'b0;
                            n_dec = 1'b0;
                            n_state = S_DONE;
                            n_phase = P_RBLD; // marks "apply finished"
                        end
                    endcase
                end
            end
            S_CIPH: begin
                mem_addr = AW'(r_round);
                n_state = S_RWAIT;
            end
            S_RWAIT: begin
                n_z = r_rdata ^ r_x;
                n_sb = 3'd0;
                n_state = S_SB;
                mem_addr = SBOX0 + AW'(r_rdata[31:24] ^ r_x[31:24]);
                n_f = '0;
                n_sb = 3'd0;
            end
            S_SB: begin
                n_f = sb_acc;
                if (r_sb == 3'd3) begin
                    n_x = r_y ^ sb_acc;
                    n_y = r_z;
                    if ((!r_dec && r_round == 5'd15) || (r_dec && r_round == 5'd2)) begin
                        mem_addr = r_dec ? AW'(1) : AW'(16);
                        n_state = S_FIN0;
                    end else begin
                        n_round = r_dec ? r_round - 5'd1 : r_round + 5'd1;
                        mem_addr = AW'(n_round);
                        n_state = S_RWAIT;
                    end
                end else begin
                    n_sb = r_sb + 3'd1;
                    case (r_sb)
                        3'd0: mem_addr = SBOX1 + AW'(r_z[23:16]);
                        3'd1: mem_addr = SBOX2 + AW'(r_z[15:8]);
                        default: mem_addr = SBOX3 + AW'(r_z[7:0]);
                    endcase
                end
            end
            S_FIN0: begin
                n_x = r_x ^ r_rdata;
                mem_addr = r_dec ? AW'(0) : AW'(17);
                n_state = S_FIN1;
            end
            S_FIN1: begin
                n_y = r_y ^ r_rdata;
                n_state = S_DONE;
            end
            S_DONE: begin
                // result block is {r_y, r_x}
                case (r_phase)
                    P_USER: begin
                        n_out.block_out = {r_y, r_x}; n_out.block_valid = 1'b1;
                        n_state = S_OUT;
                    end
                    P_ENC1: begin
                        n_cw1 = r_x; n_cw2 = r_y;
                        n_phase = P_ENC2; n_dec = 1'b0; n_round = 5'd0;
                        n_x = r_x; n_y = r_cw0;
                        n_state = S_CIPH;
                    end
                    P_ENC2: begin
                        n_cw0 = r_x; n_cw1 = r_y;
                        n_idx = '0; n_imod = 2'd0;
                        n_state = S_XRD;
                    end
                    default: begin
                        if (r_item.opcode == OP_INIT && r_idx == '0 && !r_dec) begin
                            // apply boundary (also entry from IDLE)
                            if (r_apps == 2'd0 ||
                                (!r_half && r_item.key_level - r_apps == 2'd2)) begin
                                if (!r_half) begin
                                    n_cw1 = r_cw1 << 1; n_cw2 = r_cw2 >> 1;
                                    n_half = 1'b1;
                                end
                                if (r_apps == 2'd0) begin
                                    n_out.block_out = '0; n_out.block_valid = 1'b0;
                                    n_state = S_OUT;
                                end
                            end else begin
                                n_apps = r_apps - 2'd1;
                                n_phase = P_ENC1; n_dec = 1'b0; n_round = 5'd0;
                                n_x = r_cw2; n_y = r_cw1;
                                n_state = S_CIPH;
                            end
                        end else begin
                            // rebuild step finished
                            mem_we = 1'b1; mem_addr = r_idx; mem_wdata = r_y;
                            n_state = S_RBW1;
                        end
                    end
                endcase
            end
            S_XRD: begin
                mem_addr = r_idx;
                n_state = S_XWR;
            end
            S_XWR: begin
                mem_we = 1'b1; mem_addr = r_idx;
                mem_wdata = r_rdata ^ swap_bytes(cw_sel);
                n_imod = (r_imod + 2'd1 == r_mod) ? 2'd0 : r_imod + 2'd1;
                if (r_idx == AW'(LAST_ROUND)) begin
                    n_idx = '0; n_x = '0; n_y = '0;
                    n_phase = P_RBLD; n_dec = 1'b1; n_round = LAST_ROUND;
                    n_state = S_CIPH;
                end else begin
                    n_idx = r_idx + AW'(1);
                    n_state = S_XRD;
                end
            end
            S_RBW1: begin
                mem_we = 1'b1; mem_addr = r_idx + AW'(1); mem_wdata = r_x;
                // next block input is previous output {y,x}: x'=y, y'=x
                n_x = r_y; n_y = r_x;
                if (r_idx == REBUILD_LAST) begin
                    n_idx = '0; n_dec = 1'b0;
                    n_state = S_DONE; // back to apply boundary
                end else begin
                    n_idx = r_idx + AW'(2);
                    n_round = LAST_ROUND;
                    n_state = S_CIPH;
                end
            end
            S_OUT: begin
                n_ovld = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_phase <= P_USER;
            r_cw0 <= '0; r_cw1 <= '0; r_cw2 <= '0; r_game <= '0;
            r_ovld <= 1'b0; r_apps <= '0; r_half <= 1'b0; r_dec <= 1'b0;
            r_idx <= '0; r_imod <= '0; r_mod <= 2'd1; r_round <= '0; r_sb <= '0;
        end else begin
            r_state <= n_state; r_phase <= n_phase;
            r_cw0 <= n_cw0; r_cw1 <= n_cw1; r_cw2 <= n_cw2;
            r_ovld <= n_ovld; r_apps <= n_apps; r_half <= n_half; r_dec <= n_dec;
            r_idx <= n_idx; r_imod <= n_imod; r_mod <= n_mod;
            r_round <= n_round; r_sb <= n_sb;
            if (i_cfg_we) begin
                r_game <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x; r_y <= n_y; r_z <= n_z; r_f <= n_f;
        r_out <= n_out; r_item <= n_item;
    end

`ifndef SYNTH
    a_oh: assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot(r_state))
        else $error("state not one-hot");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld |-> !in_ch.ready) else $error("ready while result pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld && !out_ch.ready |=> r_ovld) else $error("result dropped");
    a_sb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SB |-> r_sb <= 3'd3) else $error("S-box step overrun");
`endif
endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the KEY1 block cipher core with key-code schedule.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import key1_pkg::*;

    localparam int N_WORDS = 1042;

    // Clock, reset and the configuration port of the core.
    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [31:0] i_cfg_data;

    key1_in_if  in_if ();
    key1_out_if out_if ();

    key1_block_cipher_with_key_schedule_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .in_ch      (in_if.sink),
        .out_ch     (out_if.source)
    );

    // 10 ns clock, high and low half periods.
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // The checker's own copy of the key table, the code words and the game code.
    logic [31:0] key_mem [N_WORDS];
    logic [31:0] code_word [3];
    logic [31:0] game_code_q;

    // Results that the core still owes us, oldest first.
    t_out_item pending_blocks [$];
    int        mismatch_cnt;
    int        burst_left;

    // One row of the directed table. Rows whose result can be read off at a
    // glance carry it; all other rows are checked against the predictor.
    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item result;
    } t_row;
    t_row dir_rows [$];

    function automatic logic [31:0] byte_rev(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    // Round function: four S-box lookups mixed by add, xor, add.
    function automatic logic [31:0] round_mix(input logic [31:0] z);
        logic [31:0] f;
        f = key_mem[int'(SBOX0) + int'(z[31:24])];
        f = key_mem[int'(SBOX1) + int'(z[23:16])] + f;
        f = key_mem[int'(SBOX2) + int'(z[15:8])] ^ f;
        f = key_mem[int'(SBOX3) + int'(z[7:0])] + f;
        return f;
    endfunction

    function automatic logic [63:0] cipher_fwd(input logic [63:0] blk);
        logic [31:0] x, y, z;
        x = blk[63:32];
        y = blk[31:0];
        for (int r = 0; r < 16; r++) begin
            z = key_mem[r] ^ x;
            x = y ^ round_mix(z);
            y = z;
        end
        return {y ^ key_mem[17], x ^ key_mem[16]};
    endfunction

    function automatic logic [63:0] cipher_inv(input logic [63:0] blk);
        logic [31:0] x, y, z;
        x = blk[63:32];
        y = blk[31:0];
        for (int r = 17; r >= 2; r--) begin
            z = key_mem[r] ^ x;
            x = y ^ round_mix(z);
            y = z;
        end
        return {y ^ key_mem[0], x ^ key_mem[1]};
    endfunction

    // One key-code application: scramble the code words, fold them into the
    // round words and regenerate the whole table by chained decryption.
    function automatic void apply_key_code(input int modulus);
        logic [63:0] t;
        t = cipher_fwd({code_word[2], code_word[1]});
        code_word[1] = t[31:0];
        code_word[2] = t[63:32];
        t = cipher_fwd({code_word[1], code_word[0]});
        code_word[0] = t[31:0];
        code_word[1] = t[63:32];
        for (int i = 0; i < 18; i++)
            key_mem[i] ^= byte_rev(code_word[i % modulus]);
        t = '0;
        for (int i = 0; i <= int'(REBUILD_LAST); i += 2) begin
            t = cipher_inv(t);
            key_mem[i]     = t[63:32];
            key_mem[i + 1] = t[31:0];
        end
    endfunction

    // Work out the result of one accepted beat and advance the model state.
    function automatic t_out_item cipher_result(input t_in_item it);
        t_out_item res;
        int        modulus;
        res = '0;
        modulus = (it.code_modulo == 2'd0) ? 1 : int'(it.code_modulo);
        case (t_opcode'(it.opcode))
            OP_LOAD: begin
                if (it.word_index < N_WORDS)
                    key_mem[it.word_index] = it.word_value;
            end
            OP_ENC: begin
                res.block_out = cipher_fwd(it.block_in);
                res.block_valid = 1'b1;
            end
            OP_DEC: begin
                res.block_out = cipher_inv(it.block_in);
                res.block_valid = 1'b1;
            end
            default: begin
                code_word[0] = game_code_q;
                code_word[1] = game_code_q >> 1;
                code_word[2] = game_code_q << 1;
                if (it.key_level >= 2'd1) apply_key_code(modulus);
                if (it.key_level >= 2'd2) apply_key_code(modulus);
                code_word[1] = code_word[1] << 1;
                code_word[2] = code_word[2] >> 1;
                if (it.key_level == 2'd3) apply_key_code(modulus);
            end
        endcase
        return res;
    endfunction

    // Item with every field but the opcode random, so that the unused fields toggle too.
    function automatic t_in_item noise_item(input t_opcode op);
        t_in_item it;
        it.opcode      = op;
        it.word_index  = 11'($urandom_range(0, N_WORDS - 1));
        it.word_value  = $urandom;
        it.block_in    = {$urandom, $urandom};
        it.key_level   = 2'($urandom_range(0, 3));
        it.code_modulo = 2'($urandom_range(0, 3));
        return it;
    endfunction

    // Send one beat. The sender runs in bursts; between bursts valid drops
    // for a random gap. Valid is raised again only for a new item, so it
    // never sees two nonblocking updates in one time step.
    task automatic send_beat(input t_in_item it, input bit typed, input t_out_item typed_res);
        t_out_item res;
        in_if.valid <= 1'b1;
        in_if.data  <= it;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        res = cipher_result(it);
        pending_blocks.push_back(typed ? typed_res : res);
        burst_left--;
        if (burst_left <= 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
    endtask

    task automatic send_checked(input t_in_item it);
        send_beat(it, 1'b0, '0);
    endtask

    // Pause the sender until every owed result has come.
    task automatic drain;
        in_if.valid <= 1'b0;
        while (pending_blocks.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_game_code(input logic [31:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        game_code_q = v;
        @(posedge i_clk);
    endtask

    task automatic add_row(input t_in_item it, input bit typed);
        t_row row;
        row.item   = it;
        row.typed  = typed;
        row.result = '0;
        dir_rows.push_back(row);
    endtask

    // Result side: check every accepted beat against the oldest expectation,
    // and stall on a pattern of its own with stall-free stretches between.
    int unsigned rx_cycle;
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            rx_cycle <= 0;
        end else begin
            rx_cycle <= rx_cycle + 1;
            if (out_if.valid && out_if.ready) begin
                if (pending_blocks.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected result beat: block_out=%h block_valid=%b",
                                 out_if.data.block_out, out_if.data.block_valid);
                end else begin
                    want = pending_blocks.pop_front();
                    if (out_if.data.block_out !== want.block_out ||
                        out_if.data.block_valid !== want.block_valid) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("result mismatch: block_out exp %h got %h, block_valid exp %b got %b",
                                     want.block_out, out_if.data.block_out,
                                     want.block_valid, out_if.data.block_valid);
                    end
                end
            end
            // Stalls only while bits 9:8 of the cycle count are nonzero, three windows in four.
            out_if.ready <= (rx_cycle[9:8] == 2'd0) ||
                            !((rx_cycle % 7 == 3) || (rx_cycle % 11 > 7));
        end
    end

    // Hard limit on the run time; far beyond the slowest correct run.
    initial begin
        #300_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        t_in_item it;
        t_out_item none;
        int wait_cycles;
        none = '0;
        mismatch_cnt = 0;
        burst_left = $urandom_range(1, 40);
        game_code_q = '0;
        for (int i = 0; i < 3; i++) code_word[i] = '0;
        for (int i = 0; i < N_WORDS; i++) key_mem[i] = '0;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_data  <= '0;
        in_if.valid <= 1'b0;
        in_if.data  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_game_code(32'h0);

        // Fill the whole table before anything reads it; loads give a zero result.
        for (int i = 0; i < N_WORDS; i++) begin
            it = noise_item(OP_LOAD);
            it.word_index = 11'(i);
            if (i == 20) it.word_value = 32'h0;
            if (i == 21) it.word_value = 32'hFFFF_FFFF;
            send_beat(it, 1'b1, none);
        end

        // Directed table: field extremes, every opcode, ignored loads, the
        // zero modulus, and init at levels zero and one.
        it = noise_item(OP_LOAD); it.word_index = 11'd0; it.word_value = 32'hFFFF_FFFF;
        add_row(it, 1'b1);
        it = noise_item(OP_LOAD); it.word_index = 11'(N_WORDS - 1); it.word_value = 32'h0;
        add_row(it, 1'b1);
        it = noise_item(OP_LOAD); it.word_index = 11'(N_WORDS);     // just out of range
        add_row(it, 1'b1);
        it = noise_item(OP_LOAD); it.word_index = 11'h7FF;     // top of the field
        add_row(it, 1'b1);
        it = noise_item(OP_ENC); it.block_in = '0;              add_row(it, 1'b0);
        it = noise_item(OP_ENC); it.block_in = '1;              add_row(it, 1'b0);
        it = noise_item(OP_DEC); it.block_in = '0;              add_row(it, 1'b0);
        it = noise_item(OP_DEC); it.block_in = '1;              add_row(it, 1'b0);
        it = noise_item(OP_INIT); it.key_level = 2'd0; it.code_modulo = 2'd0;
        add_row(it, 1'b1);
        it = noise_item(OP_ENC);                                add_row(it, 1'b0);
        it = noise_item(OP_INIT); it.key_level = 2'd1; it.code_modulo = 2'd0;
        add_row(it, 1'b1);
        it = noise_item(OP_ENC); it.block_in = 64'h8000_0000_0000_0001;
        add_row(it, 1'b0);
        it = noise_item(OP_DEC);                                add_row(it, 1'b0);
        foreach (dir_rows[k])
            send_beat(dir_rows[k].item, dir_rows[k].typed, none);

        // Random phases, each opened by a new game code and an init (level three in the first).
        for (int ph = 0; ph < 3; ph++) begin
            drain();
            case (ph)
                0: write_game_code(32'hFFFF_FFFF);
                1: write_game_code($urandom);
                default: write_game_code(32'h8000_0001);
            endcase
            it = noise_item(OP_INIT);
            it.key_level   = (ph == 0) ? 2'd3 : 2'd1;
            it.code_modulo = (ph == 0) ? 2'd3 : 2'(ph + 1);
            send_checked(it);
            for (int n = 0; n < 230; n++) begin
                case ($urandom_range(0, 19))
                    0: begin
                        it = noise_item(OP_LOAD);
                        it.word_index = 11'($urandom_range(N_WORDS, 2047));
                    end
                    1, 2, 3: it = noise_item(OP_LOAD);
                    4: begin
                        it = noise_item(OP_INIT);
                        it.key_level = 2'd0;     // a reseed only, cheap
                    end
                    5, 6, 7, 8, 9, 10, 11: it = noise_item(OP_ENC);
                    default: it = noise_item(OP_DEC);
                endcase
                send_checked(it);
            end
        end

        drain();
        wait_cycles = 0;
        while (pending_blocks.size() != 0 && wait_cycles < 1_000_000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (200) @(posedge i_clk);
        if (mismatch_cnt == 0 && pending_blocks.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

// ----- files.f -----
hdl/key1_pkg.sv
hdl/key1_if.sv
hdl/key1_block_cipher_with_key_schedule_core.sv
test/tb_top.sv
